// File: rtl/lsc_pkg.sv
package lsc_pkg;

    // Register map
    localparam int unsigned APB_ADDR_W = 2;
    localparam int unsigned APB_DATA_W = 32;
    localparam logic [APB_ADDR_W-1:0] ADDR_MODE = 2'd0;

    // Field widths
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned POS_W  = 3;

    // Low-bit masks
    localparam logic [BYTE_W-1:0] LOW_BIT_MASK = 8'h01;
    localparam logic [BYTE_W-1:0] KEEP_MASK    = 8'hFE;

    // Operating mode
    typedef enum logic
    {
        MODE_ENCODE = 1'b0,
        MODE_DECODE = 1'b1
    } mode_t;

    // Result of one step of the codec core
    typedef struct packed
    {
        logic [BYTE_W-1:0] out_byte;
        logic              char_step;
        logic              finished;
    } step_result_t;

endpackage

// File: rtl/lsc_core.sv
module lsc_core
    import lsc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  mode_t             mode,
    input  logic              advance,
    input  logic [BYTE_W-1:0] cover_byte,
    input  logic [BYTE_W-1:0] message_byte,
    output step_result_t      result
);

    logic [POS_W-1:0]  bit_position_reg;
    logic [POS_W-1:0]  bit_position_next;
    logic [BYTE_W-1:0] char_shift_reg;
    logic [BYTE_W-1:0] char_shift_next;
    logic              stopped_reg;
    logic              stopped_next;

    logic              last_bit;
    logic              msg_bit;
    logic [BYTE_W-1:0] gathered;

    assign last_bit = (bit_position_reg == {POS_W{1'b1}});
    assign msg_bit  = message_byte[bit_position_reg];

    always_comb
    begin
        gathered                   = char_shift_reg;
        gathered[bit_position_reg] = cover_byte[0];
    end

    always_comb
    begin
        bit_position_next = bit_position_reg;
        char_shift_next   = char_shift_reg;
        stopped_next      = stopped_reg;
        result.out_byte   = '0;
        result.char_step  = 1'b0;

        case (mode)
            MODE_ENCODE:
            begin
                if (stopped_reg)
                begin
                    result.out_byte = cover_byte;
                end
                else
                begin
                    result.out_byte   = (cover_byte & KEEP_MASK)
                                      | {{(BYTE_W-1){1'b0}}, msg_bit};
                    bit_position_next = bit_position_reg + 1'b1;
                    if (last_bit)
                    begin
                        result.char_step = 1'b1;
                        if (message_byte == '0)
                            stopped_next = 1'b1;
                    end
                end
            end
            MODE_DECODE:
            begin
                if (!stopped_reg)
                begin
                    bit_position_next = bit_position_reg + 1'b1;
                    if (last_bit)
                    begin
                        result.char_step = 1'b1;
                        result.out_byte  = gathered;
                        char_shift_next  = '0;
                        if (gathered == '0)
                            stopped_next = 1'b1;
                    end
                    else
                    begin
                        char_shift_next = gathered;
                    end
                end
            end
            default:
            begin
                result.out_byte = '0;
            end
        endcase

        result.finished = stopped_next;
    end

    // Commit the state only when the held beat moves to the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_position_reg <= '0;
            char_shift_reg   <= '0;
            stopped_reg      <= 1'b0;
        end
        else if (advance)
        begin
            bit_position_reg <= bit_position_next;
            char_shift_reg   <= char_shift_next;
            stopped_reg      <= stopped_next;
        end
    end

    a_stop_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        stopped_reg |=> stopped_reg)
        else $error("stop flag cleared without reset");

    a_pos_advance: assert property (@(posedge clk) disable iff (!rst_n)
        advance && !stopped_reg |=> bit_position_reg == $past(bit_position_reg) + 1'b1)
        else $error("bit position did not advance on a live beat");

    a_finished_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> stopped_reg == $past(result.finished))
        else $error("finished flag disagrees with stop state");

endmodule

// File: rtl/lsb_stego_codec_unit.sv
// Channel     | Direction | tdata (low bit up)               | tuser (low bit up)
// s_axis      | in        | cover_byte[7:0], message_byte    | -
// m_axis      | out       | out_byte[7:0]                    | char_step, finished
// apb         | cfg       | reg 0 at 0x0: mode (bit 0)       | -
//
// One result beat for every input beat, one beat per cycle sustained while m_axis does not stall.
// The path runs through an input register, then the codec step into the
// result register; the bit update of the codec core sets the rate.
// rst_n clears mode, bit position, gathered character and the stop flag.
// A stall on m_axis holds the result register; the input register keeps
// taking a beat while it is empty or the result register is free or being emptied.
module lsb_stego_codec_unit
    import lsc_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,

    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    input  logic [2*BYTE_W-1:0]     s_axis_tdata,   // cover_byte[7:0], message_byte[15:8]

    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    output logic [BYTE_W-1:0]       m_axis_tdata,   // out_byte[7:0]
    output logic [1:0]              m_axis_tuser,   // char_step[0], finished[1]

    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [APB_ADDR_W-1:0]   paddr,
    input  logic [APB_DATA_W-1:0]   pwdata,
    output logic [APB_DATA_W-1:0]   prdata,
    output logic                    pready
);

    mode_t             mode_reg;

    logic              in_valid_reg;
    logic              in_valid_next;
    logic [BYTE_W-1:0] cover_reg;
    logic [BYTE_W-1:0] msg_reg;

    logic              out_valid_reg;
    logic              out_valid_next;
    step_result_t      out_reg;

    step_result_t      step_res;
    logic              out_free;
    logic              advance;
    logic              s_fire;
    logic              cfg_write;

    // ------------------------------------------------------------------
    // Configuration: a single mode bit, written on the APB access phase
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        prdata = '0;
        case (paddr)
            ADDR_MODE: prdata = {{(APB_DATA_W-1){1'b0}}, mode_reg};
            default:   prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= MODE_ENCODE;
        else if (cfg_write && (paddr == ADDR_MODE))
            mode_reg <= mode_t'(pwdata[0]);
    end

    // ------------------------------------------------------------------
    // Handshake: advance the input beat whenever the result slot frees up
    // ------------------------------------------------------------------
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    assign in_valid_next  = s_fire || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && !m_axis_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: no reset needed
    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            cover_reg <= s_axis_tdata[BYTE_W-1:0];
            msg_reg   <= s_axis_tdata[2*BYTE_W-1:BYTE_W];
        end
        if (advance)
            out_reg <= step_res;
    end

    // ------------------------------------------------------------------
    // Codec step: embed or extract one bit until stopped, update the shared bit state
    // ------------------------------------------------------------------
    lsc_core u_core
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .mode         (mode_reg),
        .advance      (advance),
        .cover_byte   (cover_reg),
        .message_byte (msg_reg),
        .result       (step_res)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_reg.out_byte;
    assign m_axis_tuser  = {out_reg.finished, out_reg.char_step};

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    a_decode_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (mode_reg == MODE_DECODE) && !m_axis_tuser[0]
            |-> m_axis_tdata == '0)
        else $error("decode result carries data without a character");

    a_no_loss: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("advanced beat did not reach the result register");

    a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(cover_reg) && $stable(msg_reg))
        else $error("held input beat was overwritten");

endmodule
